### hdl/erg_pkg.sv
// ----------------------------------------------------------------------------
// erg_pkg
// shared widths and types for the euclidean rhythm generator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package erg_pkg;
  localparam int unsigned CNT_W = 7;
  typedef logic [CNT_W-1:0] cnt_t;
endpackage

### hdl/erg_divider.sv
// ----------------------------------------------------------------------------
// erg_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module erg_divider (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           go,
  input  erg_pkg::cnt_t  dividend,
  input  erg_pkg::cnt_t  divisor,
  output logic           done,
  output erg_pkg::cnt_t  quotient,
  output erg_pkg::cnt_t  remainder
);
  import erg_pkg::*;

  logic [2:0]   bit_r;
  logic         run_r;
  cnt_t         q_r;
  cnt_t         rm_r;
  cnt_t         dv_r;
  logic [CNT_W:0] trial;

  assign trial = {rm_r, q_r[CNT_W-1]} - {1'b0, dv_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done  <= 1'b0;
      bit_r <= '0;
    end else begin
      done <= !go && run_r && (bit_r == '0);
      if (go) begin
        run_r <= 1'b1;
        bit_r <= 3'(CNT_W - 1);
        q_r   <= dividend;
        rm_r  <= '0;
        dv_r  <= divisor;
      end else if (run_r) begin
        if (!trial[CNT_W]) begin
          rm_r <= trial[CNT_W-1:0];
          q_r  <= {q_r[CNT_W-2:0], 1'b1};
        end else begin
          rm_r <= {rm_r[CNT_W-2:0], q_r[CNT_W-1]};
          q_r  <= {q_r[CNT_W-2:0], 1'b0};
        end
        if (bit_r == '0) begin
          run_r <= 1'b0;
        end else begin
          bit_r <= bit_r - 3'd1;
        end
      end
    end
  end

  assign quotient  = q_r;
  assign remainder = rm_r;
endmodule

### hdl/euclidean_rhythm_generator_top.sv
// ----------------------------------------------------------------------------
// euclidean_rhythm_generator_top
// bjorklund euclidean rhythm generator with one group and one remainder memory
// ----------------------------------------------------------------------------
// usage: pulse start with in_step_total and in_hit_total while busy is low.
// the block raises busy, works the request and shows one result word on
// out_pattern_bits / out_pattern_length for exactly one cycle, marked by
// out_valid. the receiver cannot stall, so the word must be taken then.
// step counts above MAX_STEPS are clipped to MAX_STEPS.
// zero hits or hits >= steps go straight from idle to the done state.
// otherwise the divider yields base and remainder, then groups and
// remainders are initialized one entry a cycle. each regroup round joins
// group/remainder pairs, with a read state and a write state per pair,
// then shifts remainders and moves leftover groups one entry a cycle, and
// the final concatenation reads one entry a cycle. the run is longest when
// two groups face a long remainder list and every round re-shifts that
// list; requests that need no regrouping skip join, shift and move.
// throughput is one request per whole run; busy stays high meanwhile.
// reset clears the sequencer only; memories need no clearing since every
// entry is written before it is read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module euclidean_rhythm_generator_top #(
  parameter int unsigned MAX_STEPS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  erg_pkg::cnt_t        in_step_total,
  input  erg_pkg::cnt_t        in_hit_total,
  output logic                 out_valid,
  output logic [63:0]          out_pattern_bits,
  output erg_pkg::cnt_t        out_pattern_length
);
  import erg_pkg::*;

  localparam int unsigned AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_INITG, S_INITR, S_CHECK, S_JOINRD, S_JOINWR,
    S_SHIFT, S_MOVE, S_CATG, S_CATR, S_DONE
  } state_t;

  typedef struct packed {
    logic [63:0] bits;
    cnt_t        len;
  } seq_t;

  // group and remainder stores
  seq_t grp_mem [MAX_STEPS];
  seq_t rem_mem [MAX_STEPS];

  state_t state_r;
  cnt_t   hits_r, ng_r, nr_r, cnt_r, base_r;
  cnt_t   i_r;
  cnt_t   j_r;
  cnt_t   acc_r;
  seq_t   g_rd_r, r_rd_r;
  logic   rd_ok_r;
  logic [63:0] pat_r;
  cnt_t   plen_r;
  logic   div_go;
  logic   div_done;
  cnt_t   div_q, div_rm;
  cnt_t   steps_clip;

  assign steps_clip = (in_step_total > cnt_t'(MAX_STEPS)) ? cnt_t'(MAX_STEPS)
                                                          : in_step_total;

  // divider loads straight from the request ports at the accepting edge
  erg_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (div_go),
    .dividend  (steps_clip),
    .divisor   (in_hit_total),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rm)
  );

  function automatic logic [63:0] place(input logic [63:0] v, input cnt_t pos);
    place = (pos >= cnt_t'(64)) ? 64'd0 : (v << pos[5:0]);
  endfunction

  // registered reads, one address each
  always_ff @(posedge clk) begin
    g_rd_r <= grp_mem[i_r[AW-1:0]];
    r_rd_r <= rem_mem[j_r[AW-1:0]];
  end

  logic        g_we, r_we;
  logic [AW-1:0] g_wa, r_wa;
  seq_t        g_wd, r_wd;

  always_ff @(posedge clk) begin
    if (g_we) grp_mem[g_wa] <= g_wd;
    if (r_we) rem_mem[r_wa] <= r_wd;
  end

  always_comb begin
    g_we = 1'b0; r_we = 1'b0;
    g_wa = i_r[AW-1:0]; r_wa = i_r[AW-1:0];
    g_wd = '{bits: 64'd1, len: base_r};
    r_wd = '{bits: 64'd0, len: 7'd1};
    case (state_r)
      S_INITG: g_we = 1'b1;
      S_INITR: r_we = 1'b1;
      S_JOINWR: begin
        g_we = 1'b1;
        g_wd = '{bits: g_rd_r.bits | place(r_rd_r.bits, g_rd_r.len),
                 len: g_rd_r.len + r_rd_r.len};
      end
      S_SHIFT: if (rd_ok_r) begin
        r_we = 1'b1;
        r_wa = AW'(j_r - cnt_r - 7'd1);
        r_wd = r_rd_r;
      end
      S_MOVE: if (rd_ok_r) begin
        r_we = 1'b1;
        r_wa = acc_r[AW-1:0];
        r_wd = g_rd_r;
      end
      default: ;
    endcase
  end

  assign div_go = (state_r == S_IDLE) && start && (in_hit_total != '0)
                  && (steps_clip > in_hit_total);
  assign busy   = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
      rd_ok_r   <= 1'b0;
    end else begin
      out_valid <= (state_r == S_DONE);
      case (state_r)
        S_IDLE: if (start) begin
          hits_r  <= in_hit_total;
          if (in_hit_total == '0) begin
            pat_r <= 64'd0; plen_r <= 7'd1; state_r <= S_DONE;
          end else if (steps_clip <= in_hit_total) begin
            pat_r <= 64'd1; plen_r <= 7'd1; state_r <= S_DONE;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: if (div_done) begin
          base_r <= div_q; ng_r <= hits_r; nr_r <= div_rm;
          i_r <= '0; state_r <= S_INITG;
        end
        S_INITG: begin
          if (i_r + 7'd1 == ng_r) begin
            i_r <= '0;
            state_r <= (nr_r == '0) ? S_CHECK : S_INITR;
          end else i_r <= i_r + 7'd1;
        end
        S_INITR: begin
          if (i_r + 7'd1 == nr_r) begin i_r <= '0; state_r <= S_CHECK; end
          else i_r <= i_r + 7'd1;
        end
        S_CHECK: begin
          i_r <= '0; j_r <= '0;
          if (nr_r > 7'd1) begin
            cnt_r   <= (ng_r < nr_r) ? ng_r : nr_r;
            state_r <= S_JOINRD;
          end else begin
            pat_r <= '0; plen_r <= '0; rd_ok_r <= 1'b0;
            state_r <= S_CATG;
          end
        end
        S_JOINRD: state_r <= S_JOINWR;  // reads of group i and remainder j settle
        S_JOINWR: begin
          if (i_r + 7'd1 == cnt_r) begin
            j_r <= cnt_r; rd_ok_r <= 1'b0; state_r <= S_SHIFT;
          end else begin
            i_r <= i_r + 7'd1; j_r <= j_r + 7'd1; state_r <= S_JOINRD;
          end
        end
        S_SHIFT: begin
          // read rem[j], write it back at j - cnt in the next cycle
          if (j_r >= nr_r) begin
            if (rd_ok_r) begin
              rd_ok_r <= 1'b0;
            end else begin
              nr_r <= nr_r - cnt_r;
              i_r  <= cnt_r; acc_r <= nr_r - cnt_r;
              state_r <= (cnt_r < ng_r) ? S_MOVE : S_CHECK;
            end
          end else begin
            rd_ok_r <= 1'b1;
            j_r <= j_r + 7'd1;
          end
          if (j_r >= nr_r && rd_ok_r) j_r <= j_r + 7'd1;
        end
        S_MOVE: begin
          // acc_r tracks the remainder count while groups move over
          if (rd_ok_r) acc_r <= acc_r + 7'd1;
          if (i_r >= ng_r) begin
            if (rd_ok_r) rd_ok_r <= 1'b0;
            else begin
              nr_r <= acc_r; ng_r <= cnt_r; state_r <= S_CHECK;
            end
          end else begin
            rd_ok_r <= 1'b1; i_r <= i_r + 7'd1;
          end
        end
        S_CATG: begin
          if (rd_ok_r) begin
            pat_r  <= pat_r | place(g_rd_r.bits, plen_r);
            plen_r <= plen_r + g_rd_r.len;
          end
          if (i_r >= ng_r) begin
            rd_ok_r <= 1'b0;
            state_r <= (nr_r == '0) ? S_DONE : S_CATR;
            j_r <= '0;
          end else begin
            rd_ok_r <= 1'b1; i_r <= i_r + 7'd1;
          end
        end
        S_CATR: begin
          if (rd_ok_r) begin
            pat_r  <= pat_r | place(r_rd_r.bits, plen_r);
            plen_r <= plen_r + r_rd_r.len;
          end
          if (j_r >= nr_r) begin
            rd_ok_r <= 1'b0;
            if (!rd_ok_r) state_r <= S_DONE;
          end else begin
            rd_ok_r <= 1'b1; j_r <= j_r + 7'd1;
          end
        end
        S_DONE: begin
          out_pattern_bits   <= pat_r;
          out_pattern_length <= plen_r;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back-to-back results");
  a_busy_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("start not taken");
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pattern_length != '0)) else $error("zero length");
`endif
endmodule
